@@ design/touch_slot_tracker_macros.svh @@
`ifndef TOUCH_SLOT_TRACKER_MACROS_SVH
`define TOUCH_SLOT_TRACKER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TST_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("touch_slot_tracker: check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define TST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("touch_slot_tracker: check failed");

`endif

@@ design/tst_pkg.sv @@
`timescale 1ns / 1ps

package tst_pkg;

  localparam int DEF_MAX_POINTS = 2;
  localparam int FRAME_POINTS   = 2;   // point records carried in one frame
  localparam int SLOT_W         = 1;
  localparam int OWNER_W        = 5;
  localparam int ID_W           = 4;
  localparam int STATE_W        = 2;
  localparam int COORD_W        = 12;
  localparam int COUNT_W        = 4;
  localparam int EVT_SHIFT      = 6;

  localparam logic [OWNER_W-1:0] SLOT_FREE = 5'd16;
  localparam logic [1:0]         EVT_MASK  = 2'd3;

  // touch states as reported downstream
  localparam logic [STATE_W-1:0] ST_OFF    = 2'd0;
  localparam logic [STATE_W-1:0] ST_ON     = 2'd1;
  localparam logic [STATE_W-1:0] ST_REPEAT = 2'd2;

  // controller event codes
  localparam logic [1:0] EVT_DOWN    = 2'd0;
  localparam logic [1:0] EVT_UP      = 2'd1;
  localparam logic [1:0] EVT_CONTACT = 2'd2;
  localparam logic [1:0] EVT_NONE    = 2'd3;

  typedef struct packed {
    logic [7:0] touch_status;
    logic [7:0] p0_x_high;
    logic [7:0] p0_x_low;
    logic [7:0] p0_y_high;
    logic [7:0] p0_y_low;
    logic [7:0] p1_x_high;
    logic [7:0] p1_x_low;
    logic [7:0] p1_y_high;
    logic [7:0] p1_y_low;
  } frame_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  event_slot;
    logic [STATE_W-1:0] event_state;
    logic [COORD_W-1:0] event_x;
    logic [COORD_W-1:0] event_y;
    logic               last_event;
  } evt_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [STATE_W-1:0] st;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } point_t;

  // per-slot outcome of one frame, handed from the mapper to a cell
  typedef struct packed {
    logic [OWNER_W-1:0] owner;
    logic [STATE_W-1:0] st;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } slot_upd_t;

  typedef struct packed {
    logic valid;
    evt_t evt;
  } entry_t;

  function automatic logic [STATE_W-1:0] decode_state(input logic [1:0] code);
    logic [STATE_W-1:0] st;
    unique case (code) inside
      EVT_DOWN:         st = ST_ON;
      EVT_CONTACT:      st = ST_REPEAT;
      EVT_UP, EVT_NONE: st = ST_OFF;
      default:          st = ST_OFF;
    endcase
    return st;
  endfunction

  function automatic point_t decode_point(input logic [7:0] xh, input logic [7:0] xl,
                                         input logic [7:0] yh, input logic [7:0] yl);
    point_t pt;
    pt.id = yh[7:4];
    pt.st = decode_state(xh[EVT_SHIFT +: 2] & EVT_MASK);
    pt.x  = {xh[3:0], xl};
    pt.y  = {yh[3:0], yl};
    return pt;
  endfunction

endpackage

@@ design/tst_map.sv @@
`timescale 1ns / 1ps

module tst_map import tst_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS
) (
  input  frame_t             frame,
  input  logic [OWNER_W-1:0] owners [MAX_POINTS],
  output slot_upd_t          upd    [MAX_POINTS]
);

  point_t             pts  [FRAME_POINTS];
  logic [OWNER_W-1:0] own  [MAX_POINTS];
  logic               seen [MAX_POINTS];
  logic               hit;
  logic [SLOT_W-1:0]  s;
  logic [COUNT_W-1:0] cnt;

  assign pts[0] = decode_point(frame.p0_x_high, frame.p0_x_low,
                               frame.p0_y_high, frame.p0_y_low);
  assign pts[1] = decode_point(frame.p1_x_high, frame.p1_x_low,
                               frame.p1_y_high, frame.p1_y_low);
  assign cnt = frame.touch_status[COUNT_W-1:0];

  // points are taken in order; a later point to the same slot wins
  always_comb begin
    hit = 1'b0;
    s   = '0;
    for (int i = 0; i < MAX_POINTS; i++) begin
      own[i]       = owners[i];
      seen[i]      = 1'b0;
      upd[i].owner = owners[i];
      upd[i].st    = ST_OFF;
      upd[i].x     = '0;
      upd[i].y     = '0;
    end
    for (int p = 0; p < MAX_POINTS; p++) begin
      if (COUNT_W'(p) < cnt) begin
        hit = 1'b0;
        s   = '0;
        for (int i = 0; i < MAX_POINTS; i++) begin
          if (!hit && own[i] == {1'b0, pts[p].id}) begin
            hit = 1'b1;
            s   = SLOT_W'(i);
          end
        end
        for (int i = 0; i < MAX_POINTS; i++) begin
          if (!hit && own[i] == SLOT_FREE) begin
            hit    = 1'b1;
            s      = SLOT_W'(i);
            own[i] = {1'b0, pts[p].id};
          end
        end
        // no free slot: falls to slot 0 with s still zero
        seen[s]  = 1'b1;
        upd[s].st = pts[p].st;
        upd[s].x  = pts[p].x;
        upd[s].y  = pts[p].y;
      end
    end
    for (int i = 0; i < MAX_POINTS; i++) begin
      upd[i].owner = seen[i] ? own[i] : SLOT_FREE;
    end
  end

endmodule

@@ design/tst_cell.sv @@
`timescale 1ns / 1ps

module tst_cell import tst_pkg::*; #(
  parameter int SLOT = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  logic               shift,
  input  slot_upd_t          upd,
  input  entry_t             entry_in,
  input  logic               later_in,
  input  logic               busy_in,
  output entry_t             entry_out,
  output logic               later_out,
  output logic               busy_out,
  output logic [OWNER_W-1:0] owner
);

  logic [STATE_W-1:0] sent_state;
  logic [COORD_W-1:0] sent_x;
  logic [COORD_W-1:0] sent_y;
  logic               a_valid;
  logic               b_valid;
  evt_t               a_evt;
  evt_t               b_evt;

  logic changed;
  logic synth;
  evt_t main_evt;
  evt_t on_evt;

  assign changed = (upd.st != sent_state) || (upd.x != sent_x) || (upd.y != sent_y);
  // off -> repeat gets an on event first
  assign synth   = changed && (sent_state == ST_OFF) && (upd.st == ST_REPEAT);

  assign main_evt = '{event_slot:  SLOT_W'(SLOT),
                      event_state: upd.st,
                      event_x:     upd.x,
                      event_y:     upd.y,
                      last_event:  !later_in};
  assign on_evt   = '{event_slot:  SLOT_W'(SLOT),
                      event_state: ST_ON,
                      event_x:     upd.x,
                      event_y:     upd.y,
                      last_event:  1'b0};

  assign later_out = changed || later_in;
  // anything queued behind this cell's front entry
  assign busy_out  = b_valid || entry_in.valid || busy_in;
  assign entry_out = '{valid: a_valid, evt: a_evt};

  always_ff @(posedge clk) begin
    if (rst) begin
      owner      <= SLOT_FREE;
      sent_state <= ST_OFF;
      sent_x     <= '0;
      sent_y     <= '0;
      a_valid    <= 1'b0;
      b_valid    <= 1'b0;
    end else if (load) begin
      owner <= upd.owner;
      if (changed) begin
        sent_state <= upd.st;
        sent_x     <= upd.x;
        sent_y     <= upd.y;
      end
      a_valid <= changed;
      b_valid <= synth;
    end else if (shift) begin
      a_valid <= b_valid;
      b_valid <= entry_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      a_evt <= synth ? on_evt : main_evt;
      b_evt <= main_evt;
    end else if (shift) begin
      a_evt <= b_evt;
      b_evt <= entry_in.evt;
    end
  end

endmodule

@@ design/touch_slot_tracker.sv @@
`timescale 1ns / 1ps

// Two-slot touch tracker. Each request is one raw controller frame (status
// byte plus two four-byte point records); the block maps track IDs onto
// persistent slots, frees slots not reported, and emits one event per slot
// whose state or position changed, in slot order, with an on event put in
// front when a slot goes straight from off to repeat. last_event marks the
// final event of a frame; a frame with no change emits nothing. Slot state
// is updated as the frame is taken, and its events are loaded into a shift
// line of two entries per slot that moves one entry a cycle toward the
// output register unless the output stalls. The next frame is taken as
// soon as the entries still waiting behind the head are gone; a stalled
// output holds the line and therefore the next frame.

`include "touch_slot_tracker_macros.svh"

module touch_slot_tracker import tst_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   frame_valid,
  output logic   frame_stall,
  input  frame_t frame,
  output logic   evt_valid,
  input  logic   evt_stall,
  output evt_t   evt
);

  logic [OWNER_W-1:0] owners [MAX_POINTS];
  slot_upd_t          upd    [MAX_POINTS];

  // chains run from the far cell toward cell 0; index MAX_POINTS is the tie-off
  // busy_chain[i]: something queued behind the front entry of cell i
  entry_t entry_chain [MAX_POINTS+1];
  logic   later_chain [MAX_POINTS+1];
  logic   busy_chain  [MAX_POINTS+1];

  logic accept;
  logic take;
  logic shift;

  tst_map #(
    .MAX_POINTS(MAX_POINTS)
  ) u_map (
    .frame (frame),
    .owners(owners),
    .upd   (upd)
  );

  assign entry_chain[MAX_POINTS] = '0;
  assign later_chain[MAX_POINTS] = 1'b0;
  assign busy_chain[MAX_POINTS]  = 1'b0;

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    tst_cell #(
      .SLOT(i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .load     (accept),
      .shift    (shift),
      .upd      (upd[i]),
      .entry_in (entry_chain[i+1]),
      .later_in (later_chain[i+1]),
      .busy_in  (busy_chain[i+1]),
      .entry_out(entry_chain[i]),
      .later_out(later_chain[i]),
      .busy_out (busy_chain[i]),
      .owner    (owners[i])
    );
  end

  // head entry moves into the output register when that register frees up
  assign take  = entry_chain[0].valid && (!evt_valid || !evt_stall);
  // an empty head is a bubble: skip it
  assign shift = !entry_chain[0].valid || take;

  // take a new frame only when the line will be empty after this cycle
  assign frame_stall = busy_chain[0] || (entry_chain[0].valid && !take);
  assign accept      = frame_valid && !frame_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      evt_valid <= 1'b0;
    end else if (!evt_valid || !evt_stall) begin
      evt_valid <= entry_chain[0].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!evt_valid || !evt_stall) begin
      evt <= entry_chain[0].evt;
    end
  end

  // only the three defined touch states go out
  `TST_ASSERT_NOW(a_state_legal, evt_valid,
    evt.event_state == ST_OFF || evt.event_state == ST_ON || evt.event_state == ST_REPEAT)

  // a frame's later events are still queued while an earlier one is shown
  `TST_ASSERT_NOW(a_more_follow, evt_valid && !evt.last_event,
    entry_chain[0].valid || busy_chain[0])

  // a taken frame leaves nothing of the previous one in the line
  `TST_ASSERT_NEXT(a_clean_load, accept && !evt_valid,
    evt_valid == $past(entry_chain[0].valid))

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_chk
    // an owner is either an ID or the free marker
    `TST_ASSERT_NOW(a_owner_legal, owners[i][OWNER_W-1], owners[i] == SLOT_FREE)
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

// Frame-in / event-out check of the two-slot touch tracker.
// One request = one raw controller frame. A scoreboard model keeps its own
// slot ownership and last-sent values, predicts the events of every frame
// at the edge it is taken, and the monitor compares each event taken from
// the block against the oldest prediction.

module testbench;
  import tst_pkg::*;

  localparam int SLOTS       = DEF_MAX_POINTS;
  localparam int STALL_LIMIT = 2000;  // cycles with no request or event taken
  localparam int HOLD_CYCLES = 200;   // long output hold in the backpressure test
  localparam int TAIL_CYCLES = 4 * DEF_MAX_POINTS + 8;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   frame_valid = 1'b0;
  logic   frame_stall;
  frame_t frame = '0;
  logic   evt_valid;
  logic   evt_stall = 1'b0;
  evt_t   evt;

  touch_slot_tracker DUT (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .frame       (frame),
    .evt_valid   (evt_valid),
    .evt_stall   (evt_stall),
    .evt         (evt)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------
  // Scoreboard model: slot owners and the values last reported per slot.
  // ---------------------------------------------------------------------
  logic [OWNER_W-1:0] slot_owner [SLOTS];
  logic [STATE_W-1:0] shown_state [SLOTS];
  logic [COORD_W-1:0] shown_x [SLOTS];
  logic [COORD_W-1:0] shown_y [SLOTS];
  evt_t               events_due [$];

  int errors         = 0;
  int frames_taken   = 0;
  int events_checked = 0;
  int quiet_cycles   = 0;

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_owner[i]  = SLOT_FREE;
      shown_state[i] = ST_OFF;
      shown_x[i]     = '0;
      shown_y[i]     = '0;
    end
  end

  // Works out the events one frame causes and queues them in order.
  function automatic void track_frame(input frame_t f);
    logic [31:0]        rec [2];
    logic [STATE_W-1:0] new_st [SLOTS];
    logic [COORD_W-1:0] new_x [SLOTS];
    logic [COORD_W-1:0] new_y [SLOTS];
    logic               seen [SLOTS];
    logic [7:0]         xh, xl, yh, yl;
    logic [STATE_W-1:0] st;
    evt_t               batch [$];
    int                 n_pts, slot;
    rec[0] = {f.p0_x_high, f.p0_x_low, f.p0_y_high, f.p0_y_low};
    rec[1] = {f.p1_x_high, f.p1_x_low, f.p1_y_high, f.p1_y_low};
    for (int i = 0; i < SLOTS; i++) begin
      new_st[i] = ST_OFF;
      new_x[i]  = '0;
      new_y[i]  = '0;
      seen[i]   = 1'b0;
    end
    n_pts = (f.touch_status[3:0] > SLOTS) ? SLOTS : int'(f.touch_status[3:0]);

    for (int p = 0; p < n_pts; p++) begin
      {xh, xl, yh, yl} = rec[p];
      // owned ID keeps its slot, else first free slot, else slot 0 unrecorded
      slot = -1;
      for (int i = SLOTS - 1; i >= 0; i--)
        if (slot_owner[i] == {1'b0, yh[7:4]}) slot = i;
      if (slot < 0) begin
        for (int i = SLOTS - 1; i >= 0; i--)
          if (slot_owner[i] == SLOT_FREE) slot = i;
        if (slot >= 0) slot_owner[slot] = {1'b0, yh[7:4]};
        else slot = 0;
      end
      case (xh[EVT_SHIFT +: 2])
        EVT_DOWN:    st = ST_ON;
        EVT_CONTACT: st = ST_REPEAT;
        default:     st = ST_OFF;
      endcase
      seen[slot]   = 1'b1;
      new_st[slot] = st;
      new_x[slot]  = {xh[3:0], xl};
      new_y[slot]  = {yh[3:0], yl};
    end

    for (int i = 0; i < SLOTS; i++)
      if (!seen[i]) slot_owner[i] = SLOT_FREE;

    for (int i = 0; i < SLOTS; i++) begin
      if (new_st[i] != shown_state[i] || new_x[i] != shown_x[i] ||
          new_y[i] != shown_y[i]) begin
        // straight from off to repeat: an on event goes out first
        if (shown_state[i] == ST_OFF && new_st[i] == ST_REPEAT)
          batch.push_back('{SLOT_W'(i), ST_ON, new_x[i], new_y[i], 1'b0});
        batch.push_back('{SLOT_W'(i), new_st[i], new_x[i], new_y[i], 1'b0});
        shown_state[i] = new_st[i];
        shown_x[i]     = new_x[i];
        shown_y[i]     = new_y[i];
      end
    end
    if (batch.size() != 0) batch[batch.size() - 1].last_event = 1'b1;
    foreach (batch[k]) events_due.push_back(batch[k]);
  endfunction

  function automatic void compare_field(input string name, input logic [11:0] want_v,
                                        input logic [11:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      errors++;
    end
  endfunction

  // ---------------------------------------------------------------------
  // Monitor: check events first, then predict the frame taken at this edge.
  // Events of a frame can never leave at the edge the frame is taken.
  // ---------------------------------------------------------------------
  evt_t want;

  always @(posedge clk) begin
    if (!rst) begin
      if (evt_valid && !evt_stall) begin
        events_checked++;
        if (events_due.size() == 0) begin
          $error("event with none expected: slot %0d state %0d x %0d y %0d last %0d",
                 evt.event_slot, evt.event_state, evt.event_x, evt.event_y,
                 evt.last_event);
          errors++;
        end else begin
          want = events_due.pop_front();
          compare_field("event_slot", 12'(want.event_slot), 12'(evt.event_slot));
          compare_field("event_state", 12'(want.event_state), 12'(evt.event_state));
          compare_field("event_x", want.event_x, evt.event_x);
          compare_field("event_y", want.event_y, evt.event_y);
          compare_field("last_event", 12'(want.last_event), 12'(evt.last_event));
        end
      end
      if (frame_valid && !frame_stall) begin
        frames_taken++;
        track_frame(frame);
      end
    end
  end

  // Watchdog: a run of cycles with nothing moving on either side ends the run.
  always @(posedge clk) begin
    if (rst || (frame_valid && !frame_stall) || (evt_valid && !evt_stall))
      quiet_cycles <= 0;
    else if (quiet_cycles >= STALL_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  // ---------------------------------------------------------------------
  // Event sink: random stall, plus a long hold when the test asks for one.
  // The hold is counted here; the test only bumps hold_asks.
  // ---------------------------------------------------------------------
  int rx_idle_pct = 0;
  int tx_idle_pct = 0;
  int hold_asks   = 0;
  int hold_seen   = 0;
  int hold_left   = 0;

  always @(negedge clk) begin
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      evt_stall <= 1'b1;
    end else
      evt_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  // ---------------------------------------------------------------------
  // Request side. After a frame is taken, valid stays up until the next
  // falling edge, where the next call either drops it or puts a new frame.
  // ---------------------------------------------------------------------
  task automatic send_frame(input frame_t f);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      frame_valid <= 1'b0;
      @(negedge clk);
    end
    frame_valid <= 1'b1;
    frame       <= f;
    do @(posedge clk); while (!(frame_valid && !frame_stall));
  endtask

  // Sender goes quiet until every predicted event has come out.
  task automatic wait_for_events();
    @(negedge clk);
    frame_valid <= 1'b0;
    while (events_due.size() != 0) @(negedge clk);
  endtask

  // Four raw bytes of one point; the unused bits 5..4 of the first byte vary.
  function automatic logic [31:0] point_bytes(input logic [1:0] code, input logic [3:0] id,
                                              input logic [11:0] x, input logic [11:0] y);
    return {code, 2'($urandom_range(3)), x[11:8], x[7:0], id, y[11:8], y[7:0]};
  endfunction

  function automatic frame_t pack_frame(input logic [7:0] status, input logic [31:0] a,
                                        input logic [31:0] b);
    return {status, a, b};
  endfunction

  function automatic logic [11:0] pick_coord();
    case ($urandom_range(5))
      0:       return 12'd0;
      1:       return 12'hFFF;
      default: return 12'($urandom_range(4095));
    endcase
  endfunction

  // Two fingers that go down, drag, sit still and lift, as a panel reports.
  logic        finger_on [2] = '{1'b0, 1'b0};
  logic [3:0]  finger_id [2];
  logic [11:0] finger_x [2];
  logic [11:0] finger_y [2];

  function automatic frame_t gesture_frame();
    logic [31:0] rec [2];
    logic [31:0] tmp;
    logic [1:0]  code;
    logic [3:0]  count;
    int          n;
    n = 0;
    rec[0] = $urandom;
    rec[1] = $urandom;
    for (int k = 0; k < 2; k++) begin
      if (!finger_on[k]) begin
        if ($urandom_range(99) >= 40) continue;
        finger_on[k] = 1'b1;
        finger_id[k] = 4'($urandom_range(15));
        finger_x[k]  = pick_coord();
        finger_y[k]  = pick_coord();
        code = $urandom_range(1) ? EVT_DOWN : EVT_CONTACT;
      end else if ($urandom_range(99) < 15) begin
        finger_on[k] = 1'b0;
        code = $urandom_range(1) ? EVT_UP : EVT_NONE;
      end else begin
        code = ($urandom_range(9) == 0) ? EVT_DOWN : EVT_CONTACT;
        if ($urandom_range(2) != 0) begin
          finger_x[k] = finger_x[k] + 12'($urandom_range(8)) - 12'd4;
          finger_y[k] = finger_y[k] + 12'($urandom_range(8)) - 12'd4;
        end
      end
      rec[n] = point_bytes(code, finger_id[k], finger_x[k], finger_y[k]);
      n++;
    end
    if (n == 2 && $urandom_range(1)) begin
      tmp    = rec[0];
      rec[0] = rec[1];
      rec[1] = tmp;
    end
    // now and then the controller misreports its point count
    count = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'(n);
    return pack_frame({4'($urandom_range(15)), count}, rec[0], rec[1]);
  endfunction

  function automatic frame_t noise_frame();
    logic [95:0] raw;
    frame_t      f;
    raw = {$urandom, $urandom, $urandom};
    f   = raw[71:0];
    if ($urandom_range(1)) f.touch_status[3:0] = 4'd2;
    return f;
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Hand-picked frames walking the slot mapping through its corner cases.
  task automatic test_directed();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    // zero count while everything is already off: nothing comes out
    send_frame(pack_frame(8'h00, point_bytes(EVT_DOWN, 4'd0, 12'd0, 12'd0),
                          point_bytes(EVT_DOWN, 4'd1, 12'd0, 12'd0)));
    // down at the origin on ID 0
    send_frame(pack_frame(8'h01, point_bytes(EVT_DOWN, 4'd0, 12'd0, 12'd0), 32'hFFFF_FFFF));
    // contact on both; ID 15 goes off to repeat, so an on event leads
    send_frame(pack_frame(8'h02, point_bytes(EVT_CONTACT, 4'd0, 12'hFFF, 12'hFFF),
                          point_bytes(EVT_CONTACT, 4'd15, 12'hFFF, 12'd0)));
    // identical frame: no change, no events; then with status high bits set
    send_frame(pack_frame(8'h02, point_bytes(EVT_CONTACT, 4'd0, 12'hFFF, 12'hFFF),
                          point_bytes(EVT_CONTACT, 4'd15, 12'hFFF, 12'd0)));
    send_frame(pack_frame(8'hF2, point_bytes(EVT_CONTACT, 4'd0, 12'hFFF, 12'hFFF),
                          point_bytes(EVT_CONTACT, 4'd15, 12'hFFF, 12'd0)));
    // up and none: off, but the decoded position is kept
    send_frame(pack_frame(8'h02, point_bytes(EVT_UP, 4'd0, 12'd100, 12'd200),
                          point_bytes(EVT_NONE, 4'd15, 12'd300, 12'd400)));
    // count 15 clamps to two; both IDs new with no free slot, both land on
    // slot 0 unrecorded, the later one wins, slot 1 is freed and cleared
    send_frame(pack_frame(8'h0F, point_bytes(EVT_CONTACT, 4'd3, 12'h111, 12'h222),
                          point_bytes(EVT_CONTACT, 4'd4, 12'h333, 12'h444)));
    // count 3 clamps; same ID twice lands on the same slot, later one wins
    send_frame(pack_frame(8'h03, point_bytes(EVT_CONTACT, 4'd5, 12'h555, 12'h666),
                          point_bytes(EVT_DOWN, 4'd5, 12'h777, 12'h888)));
    send_frame(pack_frame(8'h01, point_bytes(EVT_DOWN, 4'd5, 12'h777, 12'h889), 32'h0));
    // new ID fills slot 0, owned ID stays on slot 1, then order swapped
    send_frame(pack_frame(8'h02, point_bytes(EVT_DOWN, 4'd9, 12'h0AA, 12'h0BB),
                          point_bytes(EVT_DOWN, 4'd5, 12'h777, 12'h889)));
    send_frame(pack_frame(8'h02, point_bytes(EVT_CONTACT, 4'd5, 12'h778, 12'h889),
                          point_bytes(EVT_CONTACT, 4'd9, 12'h0AB, 12'h0BB)));
    // both slots owned and a third ID shows up: it overwrites slot 0
    send_frame(pack_frame(8'h02, point_bytes(EVT_DOWN, 4'd9, 12'h0AB, 12'h0BB),
                          point_bytes(EVT_DOWN, 4'd12, 12'hC00, 12'h00C)));
    send_frame(pack_frame(8'h00, 32'h0, 32'h0));
    send_frame(pack_frame(8'h01, point_bytes(EVT_NONE, 4'd7, 12'hFFF, 12'hFFF), 32'h0));
    send_frame(pack_frame(8'h01, point_bytes(EVT_UP, 4'd7, 12'hFFF, 12'hFFF), 32'h0));
    send_frame(pack_frame(8'h01, point_bytes(EVT_CONTACT, 4'd7, 12'hFFF, 12'hFFF), 32'h0));
    send_frame(pack_frame(8'h02, point_bytes(EVT_CONTACT, 4'd7, 12'hFFF, 12'hFFF),
                          point_bytes(EVT_DOWN, 4'd8, 12'hABC, 12'h123)));
    send_frame(pack_frame(8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_frame(pack_frame(8'h00, 32'h0, 32'h0));
    wait_for_events();
  endtask

  // Mostly finger gestures with random content, some raw noise frames.
  task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n_frames);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (n_frames)
      send_frame(($urandom_range(99) < 80) ? gesture_frame() : noise_frame());
    wait_for_events();
  endtask

  // Event side held for a long stretch while frames keep coming, so the
  // block backs up and stalls its input.
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 20;
    hold_asks   = hold_asks + 1;
    repeat (30) send_frame(gesture_frame());
    wait_for_events();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_traffic(13, 65, 110);
    test_random_traffic(65, 13, 110);
    test_random_traffic(0, 0, 80);
    test_backpressure();

    // let anything stray come out before the verdict
    repeat (TAIL_CYCLES) @(posedge clk);
    if (events_due.size() != 0) begin
      $error("%0d expected events never arrived", events_due.size());
      errors++;
    end

    $display("summary: %0d frames taken, %0d events checked", frames_taken, events_checked);
    $display("summary: slot corner cases, three idle mixes, one %0d-cycle output hold",
             HOLD_CYCLES);
    if (errors == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/tst_pkg.sv
design/tst_map.sv
design/tst_cell.sv
design/touch_slot_tracker.sv
tb/testbench.sv
